### design/sync_word_message_deframer_macros.svh
// Assertion helpers shared by the deframer modules.
// Each macro expects clk and arst_n in scope.
`ifndef SYNC_WORD_MESSAGE_DEFRAMER_MACROS_SVH
`define SYNC_WORD_MESSAGE_DEFRAMER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SWD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/swd_pkg.sv
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types and constants of the sync word message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

	localparam int COUNT_WIDTH_DEF = 20;
	localparam int LEN_W           = 20;
	localparam int BYTE_W          = 8;
	localparam int KIND_W          = 2;
	localparam int PHASE_W         = 4;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 20;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_TYPE     = 2'd1;

	localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RST = 20'd928332;
	localparam logic [BYTE_W-1:0] VIDEO_TYPE_RST     = 8'h02;

	// Sync sequence bytes and the value sent with the final payload byte.
	localparam logic [BYTE_W-1:0] SYNC_A      = 8'hFF;
	localparam logic [BYTE_W-1:0] SYNC_B      = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_C      = 8'h55;
	localparam logic [BYTE_W-1:0] FINAL_VALUE = 8'd6;

	// Record kinds.
	localparam logic [KIND_W-1:0] KIND_ALARM   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

	// Parser phase codes.
	localparam logic [PHASE_W-1:0] PH_SYNC1   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_SYNC2   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_SYNC3   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SYNC4   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_VALUE   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_COLS    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ROWS    = 4'd7;
	localparam logic [PHASE_W-1:0] PH_DEPTH   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_INDEX   = 4'd9;
	localparam logic [PHASE_W-1:0] PH_TOTAL   = 4'd10;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd11;

	typedef struct packed {
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] video_type_code;
	} swd_cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] record_kind;
		logic [BYTE_W-1:0] type_byte;
		logic [BYTE_W-1:0] value_byte;
		logic [BYTE_W-1:0] image_cols;
		logic [BYTE_W-1:0] image_rows;
		logic [BYTE_W-1:0] image_depth;
		logic [BYTE_W-1:0] fragment_index;
		logic [BYTE_W-1:0] fragment_total;
		logic [BYTE_W-1:0] payload_byte;
		logic              last_byte;
	} swd_record_t;

endpackage

`default_nettype wire

### design/swd_cfg_regs.sv
// ----------------------------------------------------------------------------
// swd_cfg_regs
// Configuration registers: payload length and video type code.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [swd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [swd_pkg::CFG_DATA_W-1:0]      cfg_data,
	output swd_pkg::swd_cfg_t                        cfg
);

	logic [swd_pkg::LEN_W-1:0]  payload_length_q;
	logic [swd_pkg::BYTE_W-1:0] video_type_code_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q  <= swd_pkg::PAYLOAD_LENGTH_RST;
			video_type_code_q <= swd_pkg::VIDEO_TYPE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				swd_pkg::REG_PAYLOAD_LENGTH: begin
					payload_length_q <= cfg_data[swd_pkg::LEN_W-1:0];
				end
				swd_pkg::REG_VIDEO_TYPE: begin
					video_type_code_q <= cfg_data[swd_pkg::BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.payload_length  = payload_length_q;
	assign cfg.video_type_code = video_type_code_q;

endmodule

`default_nettype wire

### design/swd_parser.sv
// ----------------------------------------------------------------------------
// swd_parser
// Phase register, held header bytes and payload counter; forms one record.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_word_message_deframer_macros.svh"

module swd_parser #(
	parameter int COUNT_WIDTH = swd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            beat,
	input  wire logic [swd_pkg::BYTE_W-1:0]      data_byte,
	input  wire swd_pkg::swd_cfg_t               cfg,
	output logic                                 rec_valid,
	output swd_pkg::swd_record_t                 rec
);

	logic [swd_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]      count_q, count_d, count_inc, len_cmp;
	logic [swd_pkg::BYTE_W-1:0]  type_q, source_q, cols_q, rows_q, depth_q, index_q, total_q;
	logic                        is_last;

	// Lengths are compared modulo the counter width.
	assign len_cmp   = COUNT_WIDTH'(cfg.payload_length);
	assign count_inc = count_q + 1'b1;
	assign is_last   = (count_inc == len_cmp);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		rec_valid = 1'b0;
		rec       = '0;
		rec.type_byte = type_q;
		unique case (phase_q)
			swd_pkg::PH_SYNC1: begin
				if (data_byte == swd_pkg::SYNC_A) phase_d = swd_pkg::PH_SYNC2;
			end
			swd_pkg::PH_SYNC2: begin
				if (data_byte == swd_pkg::SYNC_A) phase_d = swd_pkg::PH_SYNC3;
			end
			swd_pkg::PH_SYNC3: begin
				if (data_byte == swd_pkg::SYNC_B) phase_d = swd_pkg::PH_SYNC4;
			end
			swd_pkg::PH_SYNC4: begin
				if (data_byte == swd_pkg::SYNC_C) phase_d = swd_pkg::PH_TYPE;
			end
			swd_pkg::PH_TYPE:  phase_d = swd_pkg::PH_VALUE;
			swd_pkg::PH_VALUE: begin
				if (type_q != cfg.video_type_code) begin
					phase_d         = swd_pkg::PH_SYNC1;
					rec_valid       = beat;
					rec.record_kind = swd_pkg::KIND_ALARM;
					rec.value_byte  = data_byte;
				end else begin
					phase_d = swd_pkg::PH_COLS;
				end
			end
			swd_pkg::PH_COLS:  phase_d = swd_pkg::PH_ROWS;
			swd_pkg::PH_ROWS:  phase_d = swd_pkg::PH_DEPTH;
			swd_pkg::PH_DEPTH: phase_d = swd_pkg::PH_INDEX;
			swd_pkg::PH_INDEX: phase_d = swd_pkg::PH_TOTAL;
			swd_pkg::PH_TOTAL: begin
				phase_d            = swd_pkg::PH_PAYLOAD;
				count_d            = '0;
				rec_valid          = beat;
				rec.record_kind    = swd_pkg::KIND_HEADER;
				rec.value_byte     = source_q;
				rec.image_cols     = cols_q;
				rec.image_rows     = rows_q;
				rec.image_depth    = depth_q;
				rec.fragment_index = index_q;
				rec.fragment_total = data_byte;
			end
			swd_pkg::PH_PAYLOAD: begin
				rec_valid          = beat;
				rec.record_kind    = swd_pkg::KIND_PAYLOAD;
				rec.image_cols     = cols_q;
				rec.image_rows     = rows_q;
				rec.image_depth    = depth_q;
				rec.fragment_index = index_q;
				rec.fragment_total = total_q;
				rec.payload_byte   = data_byte;
				rec.last_byte      = is_last;
				if (is_last) begin
					phase_d        = swd_pkg::PH_SYNC1;
					count_d        = '0;
					rec.value_byte = swd_pkg::FINAL_VALUE;
				end else begin
					count_d        = count_inc;
					rec.value_byte = source_q;
				end
			end
			default: phase_d = swd_pkg::PH_SYNC1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swd_pkg::PH_SYNC1;
			count_q <= '0;
		end else if (beat) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// Held header bytes; each is written before any record reads it.
	always_ff @(posedge clk) begin
		if (beat) begin
			if (phase_q == swd_pkg::PH_TYPE)  type_q <= data_byte;
			if (phase_q == swd_pkg::PH_VALUE && type_q == cfg.video_type_code) begin
				source_q <= data_byte;
			end
			if (phase_q == swd_pkg::PH_COLS)  cols_q  <= data_byte;
			if (phase_q == swd_pkg::PH_ROWS)  rows_q  <= data_byte;
			if (phase_q == swd_pkg::PH_DEPTH) depth_q <= data_byte;
			if (phase_q == swd_pkg::PH_INDEX) index_q <= data_byte;
			if (phase_q == swd_pkg::PH_TOTAL) total_q <= data_byte;
		end
	end

	`SWD_ASSERT_ALWAYS(a_payload_emits, !(beat && phase_q == swd_pkg::PH_PAYLOAD) || rec_valid, "payload beat without a record")
	`SWD_ASSERT_ALWAYS(a_count_idle, phase_q == swd_pkg::PH_PAYLOAD || count_q == '0, "payload counter nonzero outside payload")
	`SWD_ASSERT_NEXT(a_last_rehunts, rec_valid && rec.last_byte, phase_q == swd_pkg::PH_SYNC1, "final payload byte did not restart the hunt")

endmodule

`default_nettype wire

### design/swd_out_stage.sv
// ----------------------------------------------------------------------------
// swd_out_stage
// Result register with a skid entry so input acceptance survives one stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_word_message_deframer_macros.svh"

module swd_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire swd_pkg::swd_record_t rec,
	output logic                      accept_ok,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output swd_pkg::swd_record_t      out_rec
);

	logic                 main_valid_q, skid_valid_q;
	swd_pkg::swd_record_t main_q, skid_q;
	logic                 pop;

	assign pop       = main_valid_q && out_ready;
	assign accept_ok = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_rec   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= rec;
			end
		end else if (push) begin
			skid_q <= rec;
		end
	end

	`SWD_ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_q || main_valid_q, "skid entry valid while result register empty")
	`SWD_ASSERT_ALWAYS(a_no_push_when_full, !(push && skid_valid_q), "record pushed while skid entry full")
	`SWD_ASSERT_NEXT(a_stall_holds, main_valid_q && !out_ready, out_valid && main_q == $past(main_q), "stalled result changed")

endmodule

`default_nettype wire

### design/sync_word_message_deframer.sv
// ----------------------------------------------------------------------------
// sync_word_message_deframer
// Byte-serial deframer for a sync-word framed alarm and video message stream.
// ----------------------------------------------------------------------------
// Use: bytes enter one per beat on the input channel (in_valid, in_ready,
// data_byte). The block hunts for FF FF AA 55, one byte at a time, skipping
// anything else at each stage. It then takes a type byte and a value byte.
// A type other than the video type code yields one alarm record; the video
// type reads five header bytes, yields a header record on the last of them,
// and then yields one payload record per byte, with last_byte set on the
// final one. Other bytes yield no record.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the payload length (index 0) and the video type code (index 1);
// cfg_ready is always high and other indexes are dropped.
// Output: a record is registered into the result register, or the skid entry
// if that stalls. Throughput: one input beat per cycle while in_ready is high,
// set by the single phase register and payload counter update in the parser.
// Stalls: a result register plus one skid entry hold records while out_ready
// is low; in_ready drops only once the skid entry is full.
// Reset: the hunt restarts at the first sync byte, both output entries are
// emptied, and the registers return to length 928332 and video type 2.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_message_deframer #(
	parameter int COUNT_WIDTH = swd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input byte channel.
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [swd_pkg::BYTE_W-1:0]          data_byte,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [swd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [swd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Record channel.
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [swd_pkg::KIND_W-1:0]               record_kind,
	output logic [swd_pkg::BYTE_W-1:0]               type_byte,
	output logic [swd_pkg::BYTE_W-1:0]               value_byte,
	output logic [swd_pkg::BYTE_W-1:0]               image_cols,
	output logic [swd_pkg::BYTE_W-1:0]               image_rows,
	output logic [swd_pkg::BYTE_W-1:0]               image_depth,
	output logic [swd_pkg::BYTE_W-1:0]               fragment_index,
	output logic [swd_pkg::BYTE_W-1:0]               fragment_total,
	output logic [swd_pkg::BYTE_W-1:0]               payload_byte,
	output logic                                     last_byte
);

	swd_pkg::swd_cfg_t    cfg;
	swd_pkg::swd_record_t rec;
	swd_pkg::swd_record_t out_rec;
	logic                 beat;
	logic                 rec_valid;

	// A beat is taken whenever the skid entry is free, so the parser never
	// has to hold a byte back.
	assign beat = in_valid && in_ready;

	swd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swd_parser #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.data_byte (data_byte),
		.cfg       (cfg),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	swd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_valid),
		.rec       (rec),
		.accept_ok (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rec   (out_rec)
	);

	// Unpack the held record onto the individual field ports.
	assign record_kind    = out_rec.record_kind;
	assign type_byte      = out_rec.type_byte;
	assign value_byte     = out_rec.value_byte;
	assign image_cols     = out_rec.image_cols;
	assign image_rows     = out_rec.image_rows;
	assign image_depth    = out_rec.image_depth;
	assign fragment_index = out_rec.fragment_index;
	assign fragment_total = out_rec.fragment_total;
	assign payload_byte   = out_rec.payload_byte;
	assign last_byte      = out_rec.last_byte;

endmodule

`default_nettype wire

### sim/sync_word_message_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_word_message_deframer_tb
// Self-checking bench for the sync word deframer. A queue-fed driver sends
// stream bytes and a monitor predicts the alarm, header and payload records.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_message_deframer_tb;

	typedef logic [swd_pkg::BYTE_W-1:0]          byte_t;
	typedef logic [swd_pkg::LEN_W-1:0]           len_t;
	typedef logic [swd_pkg::COUNT_WIDTH_DEF-1:0] count_t;
	typedef logic [swd_pkg::CFG_DATA_W-1:0]      cfg_word_t;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int MAX_GAP       = 18;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_ITEMS  = 950;
	localparam int PHASE_ITEMS   = 100;
	localparam int PRESSURE_PHASE = 3;
	localparam int HOLD_CYCLES   = 250;

	// These indexes fall outside the register map and must be dropped.
	localparam logic [swd_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [swd_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	logic [swd_pkg::BYTE_W-1:0]      data_byte = '0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [swd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [swd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [swd_pkg::KIND_W-1:0]      record_kind;
	logic [swd_pkg::BYTE_W-1:0]      type_byte;
	logic [swd_pkg::BYTE_W-1:0]      value_byte;
	logic [swd_pkg::BYTE_W-1:0]      image_cols;
	logic [swd_pkg::BYTE_W-1:0]      image_rows;
	logic [swd_pkg::BYTE_W-1:0]      image_depth;
	logic [swd_pkg::BYTE_W-1:0]      fragment_index;
	logic [swd_pkg::BYTE_W-1:0]      fragment_total;
	logic [swd_pkg::BYTE_W-1:0]      payload_byte;
	logic                            last_byte;

	sync_word_message_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_kind    (record_kind),
		.type_byte      (type_byte),
		.value_byte     (value_byte),
		.image_cols     (image_cols),
		.image_rows     (image_rows),
		.image_depth    (image_depth),
		.fragment_index (fragment_index),
		.fragment_total (fragment_total),
		.payload_byte   (payload_byte),
		.last_byte      (last_byte)
	);

	// 20 time unit clock, low half first.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shared bench state.
	// ------------------------------------------------------------------
	logic [swd_pkg::BYTE_W-1:0] bytes_to_send[$];   // stream bytes not yet on the port
	swd_pkg::swd_record_t       due_records[$];     // predicted records, oldest first
	int                         bytes_queued   = 0;
	int                         bytes_accepted = 0;
	int                         noise_items    = 0; // bytes the hunt simply skips
	int                         fail_count     = 0;
	int                         cycle_count    = 0;

	// Handshake flags, set at the rising edge and read at the falling edge.
	bit byte_taken   = 1'b0;
	bit record_taken = 1'b0;

	bit sender_idling   = 1'b1;
	bit receiver_idling = 1'b1;
	int tx_gap          = 0;
	int rx_gap          = 0;
	int rx_hold_cycles  = 0;

	// ------------------------------------------------------------------
	// Parser shadow: register copies and the held message fields.
	// ------------------------------------------------------------------
	logic [swd_pkg::LEN_W-1:0]   len_reg   = swd_pkg::PAYLOAD_LENGTH_RST;
	logic [swd_pkg::BYTE_W-1:0]  vtype_reg = swd_pkg::VIDEO_TYPE_RST;
	logic [swd_pkg::PHASE_W-1:0] ps_phase  = swd_pkg::PH_SYNC1;
	logic [swd_pkg::BYTE_W-1:0]  ps_type   = '0;
	logic [swd_pkg::BYTE_W-1:0]  ps_source = '0;
	logic [swd_pkg::BYTE_W-1:0]  ps_cols   = '0;
	logic [swd_pkg::BYTE_W-1:0]  ps_rows   = '0;
	logic [swd_pkg::BYTE_W-1:0]  ps_depth  = '0;
	logic [swd_pkg::BYTE_W-1:0]  ps_index  = '0;
	logic [swd_pkg::BYTE_W-1:0]  ps_total  = '0;
	count_t                      ps_count  = '0;

	// Header fields ride along on header and payload records only; an alarm
	// carries zeros there.
	function automatic swd_pkg::swd_record_t make_record(
			logic [swd_pkg::KIND_W-1:0] kind, logic [swd_pkg::BYTE_W-1:0] value,
			logic [swd_pkg::BYTE_W-1:0] pay, logic is_last, bit with_hdr);
		swd_pkg::swd_record_t r;
		r.record_kind    = kind;
		r.type_byte      = ps_type;
		r.value_byte     = value;
		r.image_cols     = with_hdr ? ps_cols  : '0;
		r.image_rows     = with_hdr ? ps_rows  : '0;
		r.image_depth    = with_hdr ? ps_depth : '0;
		r.fragment_index = with_hdr ? ps_index : '0;
		r.fragment_total = with_hdr ? ps_total : '0;
		r.payload_byte   = pay;
		r.last_byte      = is_last;
		return r;
	endfunction

	// Advance the shadow parser by one accepted byte and queue the record it
	// yields, if any.
	task automatic parse_byte(input logic [swd_pkg::BYTE_W-1:0] b);
		count_t next_count;
		case (ps_phase)
			// Each hunting stage waits for its own byte and skips anything
			// else; a wrong byte never throws the hunt back to the start.
			swd_pkg::PH_SYNC1: if (b == swd_pkg::SYNC_A) ps_phase = swd_pkg::PH_SYNC2;
			swd_pkg::PH_SYNC2: if (b == swd_pkg::SYNC_A) ps_phase = swd_pkg::PH_SYNC3;
			swd_pkg::PH_SYNC3: if (b == swd_pkg::SYNC_B) ps_phase = swd_pkg::PH_SYNC4;
			swd_pkg::PH_SYNC4: if (b == swd_pkg::SYNC_C) ps_phase = swd_pkg::PH_TYPE;
			swd_pkg::PH_TYPE: begin
				ps_type  = b;
				ps_phase = swd_pkg::PH_VALUE;
			end
			// The type is checked against the register only now, so a write
			// between the type and value bytes counts.
			swd_pkg::PH_VALUE: begin
				if (ps_type != vtype_reg) begin
					due_records.push_back(make_record(swd_pkg::KIND_ALARM, b, '0, 1'b0,
						1'b0));
					ps_phase = swd_pkg::PH_SYNC1;
				end else begin
					ps_source = b;
					ps_phase  = swd_pkg::PH_COLS;
				end
			end
			swd_pkg::PH_COLS: begin
				ps_cols  = b;
				ps_phase = swd_pkg::PH_ROWS;
			end
			swd_pkg::PH_ROWS: begin
				ps_rows  = b;
				ps_phase = swd_pkg::PH_DEPTH;
			end
			swd_pkg::PH_DEPTH: begin
				ps_depth = b;
				ps_phase = swd_pkg::PH_INDEX;
			end
			swd_pkg::PH_INDEX: begin
				ps_index = b;
				ps_phase = swd_pkg::PH_TOTAL;
			end
			swd_pkg::PH_TOTAL: begin
				ps_total = b;
				ps_count = '0;
				ps_phase = swd_pkg::PH_PAYLOAD;
				due_records.push_back(make_record(swd_pkg::KIND_HEADER, ps_source, '0, 1'b0,
					1'b1));
			end
			// The counter wraps at its width, so a zero length runs for a
			// full counter period and a length of one ends on the first byte.
			swd_pkg::PH_PAYLOAD: begin
				next_count = ps_count + 1'b1;
				if (next_count == count_t'(len_reg)) begin
					due_records.push_back(make_record(swd_pkg::KIND_PAYLOAD,
						swd_pkg::FINAL_VALUE, b, 1'b1, 1'b1));
					ps_count = '0;
					ps_phase = swd_pkg::PH_SYNC1;
				end else begin
					due_records.push_back(make_record(swd_pkg::KIND_PAYLOAD, ps_source, b,
						1'b0, 1'b1));
					ps_count = next_count;
				end
			end
			default: ps_phase = swd_pkg::PH_SYNC1;
		endcase
	endtask

	function automatic string record_text(swd_pkg::swd_record_t r);
		return $sformatf({"kind=%0d type=%h value=%h cols=%h rows=%h depth=%h ",
			"index=%h total=%h payload=%h last=%b"}, r.record_kind, r.type_byte,
			r.value_byte, r.image_cols, r.image_rows, r.image_depth, r.fragment_index,
			r.fragment_total, r.payload_byte, r.last_byte);
	endfunction

	// Only the first few failures are printed; the rest are only counted.
	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0d: %s", cycle_count, msg);
		end
	endtask

	// Compare one record beat from the block with the oldest prediction.
	task automatic check_record();
		swd_pkg::swd_record_t got;
		swd_pkg::swd_record_t want;
		string                bad;
		got.record_kind    = record_kind;
		got.type_byte      = type_byte;
		got.value_byte     = value_byte;
		got.image_cols     = image_cols;
		got.image_rows     = image_rows;
		got.image_depth    = image_depth;
		got.fragment_index = fragment_index;
		got.fragment_total = fragment_total;
		got.payload_byte   = payload_byte;
		got.last_byte      = last_byte;
		if (due_records.size() == 0) begin
			note_failure({"record with nothing predicted: ", record_text(got)});
		end else begin
			want = due_records.pop_front();
			bad  = "";
			if (got.record_kind !== want.record_kind) bad = {bad, " record_kind"};
			if (got.type_byte !== want.type_byte) bad = {bad, " type_byte"};
			if (got.value_byte !== want.value_byte) bad = {bad, " value_byte"};
			if (got.image_cols !== want.image_cols) bad = {bad, " image_cols"};
			if (got.image_rows !== want.image_rows) bad = {bad, " image_rows"};
			if (got.image_depth !== want.image_depth) bad = {bad, " image_depth"};
			if (got.fragment_index !== want.fragment_index) bad = {bad, " fragment_index"};
			if (got.fragment_total !== want.fragment_total) bad = {bad, " fragment_total"};
			if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
			if (got.last_byte !== want.last_byte) bad = {bad, " last_byte"};
			if (bad != "") begin
				note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s", bad,
					record_text(want), record_text(got)));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge, where the inputs
	// have been stable since the falling edge and the block's outputs still
	// show their pre-edge values.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		byte_taken   = 1'b0;
		record_taken = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					swd_pkg::REG_PAYLOAD_LENGTH: len_reg   = cfg_data[swd_pkg::LEN_W-1:0];
					swd_pkg::REG_VIDEO_TYPE:     vtype_reg = cfg_data[swd_pkg::BYTE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				byte_taken = 1'b1;
				bytes_accepted++;
				parse_byte(data_byte);
			end
			if (out_valid && out_ready) begin
				record_taken = 1'b1;
				check_record();
			end
		end
	end

	// ------------------------------------------------------------------
	// Byte driver. It holds a beat until it is taken, then waits its drawn
	// gap before offering the next byte from the queue.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || byte_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (bytes_to_send.size() != 0) begin
				in_valid  <= 1'b1;
				data_byte <= bytes_to_send.pop_front();
				tx_gap = sender_idling ? $urandom_range(0, MAX_GAP) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Record receiver. A fresh stall is drawn after each record beat; a long
	// hold-off, when armed, overrides it so the block fills up and pushes
	// back on its input.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (record_taken) begin
				rx_gap = receiver_idling ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run that hangs or loses records ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. The stimulus side keeps its own notion of the
	// current length and video type to build messages that match them.
	// ------------------------------------------------------------------
	logic [swd_pkg::LEN_W-1:0]  cur_len  = swd_pkg::PAYLOAD_LENGTH_RST;
	logic [swd_pkg::BYTE_W-1:0] cur_type = swd_pkg::VIDEO_TYPE_RST;

	task automatic push_byte(input logic [swd_pkg::BYTE_W-1:0] b);
		bytes_to_send.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_noise(input int n);
		repeat (n) push_byte(byte_t'($urandom_range(0, 255)));
		noise_items += n;
	endtask

	task automatic push_sync();
		push_byte(swd_pkg::SYNC_A);
		push_byte(swd_pkg::SYNC_A);
		push_byte(swd_pkg::SYNC_B);
		push_byte(swd_pkg::SYNC_C);
	endtask

	// Sync with junk between its bytes; the hunt should skip the junk.
	task automatic push_broken_sync();
		push_byte(swd_pkg::SYNC_A);
		push_byte(byte_t'($urandom_range(0, 255)));
		push_byte(swd_pkg::SYNC_A);
		push_byte(byte_t'($urandom_range(0, 255)));
		push_byte(swd_pkg::SYNC_B);
		push_byte(byte_t'($urandom_range(0, 255)));
		push_byte(swd_pkg::SYNC_C);
	endtask

	task automatic push_payload(input int n);
		repeat (n) push_byte(byte_t'($urandom_range(0, 255)));
	endtask

	task automatic push_alarm();
		logic [swd_pkg::BYTE_W-1:0] t;
		do t = byte_t'($urandom_range(0, 255)); while (t == cur_type);
		push_sync();
		push_byte(t);
		push_byte(byte_t'($urandom_range(0, 255)));
	endtask

	// Type, source id and the five header bytes, then n payload bytes.
	task automatic push_video_body(input int n);
		push_byte(cur_type);
		push_byte(byte_t'($urandom_range(0, 255)));
		repeat (5) push_byte(byte_t'($urandom_range(0, 255)));
		push_payload(n);
	endtask

	// Wait until every byte is in, every record is out, and the parser has
	// had time to settle on bytes that yield nothing.
	task automatic wait_idle();
		do @(negedge clk); while (bytes_accepted != bytes_queued || due_records.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [swd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [swd_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A length that a whole message could never reach in this run (zero or
	// the maximum) is set, part of the payload is sent, and then the length
	// is pulled in mid-message so the message ends a few bytes later.
	task automatic run_cut_short(input logic [swd_pkg::LEN_W-1:0] len_value);
		int head_n;
		int tail_n;
		head_n = $urandom_range(5, 40);
		tail_n = $urandom_range(1, 8);
		write_reg(swd_pkg::REG_PAYLOAD_LENGTH, len_value);
		push_sync();
		push_video_body(head_n);
		wait_idle();
		cur_len = len_t'(head_n + tail_n);
		write_reg(swd_pkg::REG_PAYLOAD_LENGTH, cur_len);
		push_payload(tail_n);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		logic [swd_pkg::CFG_DATA_W-1:0] cfg_word;
		logic [swd_pkg::LEN_W-1:0]      len_pick;
		logic [swd_pkg::BYTE_W-1:0]     type_pick;
		int                             phase_no;
		int                             start_items;
		int                             random_items;
		phase_no     = 0;
		random_items = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: skipped bytes in the hunt, then an alarm with the
		// extreme type and value bytes.
		push_noise(2);
		push_byte(swd_pkg::SYNC_A);
		push_byte(8'h3C);
		push_byte(swd_pkg::SYNC_A);
		push_byte(swd_pkg::SYNC_B);
		push_byte(swd_pkg::SYNC_C);
		push_byte(8'h00);
		push_byte(8'hFF);
		// A video message under the reset length; two payload bytes go out,
		// then the length is cut to three so the next byte is the last.
		push_sync();
		push_byte(swd_pkg::VIDEO_TYPE_RST);
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte(8'h02);
		push_byte(8'h03);
		push_byte(8'h00);
		push_byte(8'hFF);
		wait_idle();
		write_reg(swd_pkg::REG_PAYLOAD_LENGTH, cfg_word_t'(3));
		push_byte(8'hA5);
		wait_idle();

		// Length one and the top video type: the first payload byte is the
		// final one, and the old video type now yields an alarm.
		cur_len  = len_t'(1);
		cur_type = 8'hFF;
		write_reg(swd_pkg::REG_PAYLOAD_LENGTH, cur_len);
		write_reg(swd_pkg::REG_VIDEO_TYPE, {12'hFFF, cur_type});
		write_reg(REG_SPARE_2, '1);
		push_sync();
		push_byte(8'hFF);
		push_byte(8'h5A);
		push_byte(8'h10);
		push_byte(8'h20);
		push_byte(8'h30);
		push_byte(8'h40);
		push_byte(8'h50);
		push_byte(8'h7E);
		push_sync();
		push_byte(swd_pkg::VIDEO_TYPE_RST);
		push_byte(8'h11);
		wait_idle();

		// Zero length wraps the counter; the maximum length is the other end.
		run_cut_short('0);
		cur_type = 8'h00;
		write_reg(swd_pkg::REG_VIDEO_TYPE, '0);
		write_reg(REG_SPARE_3, '0);
		run_cut_short('1);

		// Random phases, each with its own settings and idling mix. Most
		// traffic is well-formed messages with random content.
		while (random_items < RANDOM_ITEMS) begin
			phase_no++;
			case ($urandom_range(0, 4))
				0:       len_pick = len_t'(1);
				1:       len_pick = len_t'(2);
				2:       len_pick = len_t'($urandom_range(3, 8));
				3:       len_pick = len_t'($urandom_range(1, 24));
				default: len_pick = len_t'($urandom_range(9, 40));
			endcase
			case ($urandom_range(0, 3))
				0:       type_pick = 8'h00;
				1:       type_pick = 8'hFF;
				default: type_pick = byte_t'($urandom_range(0, 255));
			endcase
			if (phase_no == PRESSURE_PHASE) len_pick = len_t'(60);
			cur_len  = len_pick;
			cur_type = type_pick;
			write_reg(swd_pkg::REG_PAYLOAD_LENGTH, cur_len);
			cfg_word = cfg_word_t'($urandom());
			cfg_word[swd_pkg::BYTE_W-1:0] = cur_type;
			write_reg(swd_pkg::REG_VIDEO_TYPE, cfg_word);
			if ($urandom_range(0, 3) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					cfg_word_t'($urandom()));
			end
			sender_idling   = $urandom_range(0, 3) != 0;
			receiver_idling = $urandom_range(0, 3) != 0;
			// One phase sends back to back into a receiver that holds off,
			// so the output entries fill and the input stalls.
			if (phase_no == PRESSURE_PHASE) begin
				sender_idling  = 1'b0;
				rx_hold_cycles = HOLD_CYCLES;
			end
			start_items = bytes_queued - noise_items;
			while (bytes_queued - noise_items - start_items < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0, 1: push_alarm();
					8: begin
						push_broken_sync();
						push_video_body(cur_len);
					end
					9: push_noise($urandom_range(1, 6));
					default: begin
						push_sync();
						push_video_body(cur_len);
					end
				endcase
			end
			wait_idle();
			random_items += bytes_queued - noise_items - start_items;
		end

		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		wait_idle();
		if (due_records.size() != 0) begin
			note_failure($sformatf("%0d predicted records never came", due_records.size()));
		end
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/swd_pkg.sv
design/swd_cfg_regs.sv
design/swd_parser.sv
design/swd_out_stage.sv
design/sync_word_message_deframer.sv
sim/sync_word_message_deframer_tb.sv
